// File: hdl/rtdtp_pkg.sv
package rtdtp_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned RES_W    = 24;
    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned FILL_W   = 5;
    localparam int unsigned SERIES_W = 16;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SERIES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_CNT  = 2'd2;

    localparam logic [RES_W-1:0] RES_SAT = {RES_W{1'b1}};

    typedef struct packed {
        logic                   mode;
        logic [5:0]             table_index;
        logic [RES_W-1:0]       table_resistance;
        logic signed [TEMP_W-1:0] table_temperature;
        logic [SAMPLE_W-1:0]    adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [RES_W-1:0]         resistance;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [TEMP_W-1:0] smoothed_temperature;
        logic [FILL_W-1:0]        window_fill;
    } t_out_item;

    // queued work between front and back
    typedef struct packed {
        logic                   is_write;
        logic [5:0]             index;
        logic [RES_W-1:0]       res;
        logic signed [TEMP_W-1:0] temp;
        logic [SAMPLE_W-1:0]    avg;
    } t_job;

endpackage

// File: hdl/rtdtp_stream_if.sv
interface rtdtp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rtdtp_divider.sv
module rtdtp_divider
    import rtdtp_pkg::*;
#(
    parameter int unsigned NUM_W = 40,
    parameter int unsigned DEN_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_trial;

    // one quotient bit per cycle, restoring
    assign n_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_den}) begin
                    r_rem <= n_trial - {1'b0, r_den};
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: hdl/rtdtp_front.sv
module rtdtp_front
    import rtdtp_pkg::*;
#(
    parameter int unsigned BURST = 10,
    parameter int unsigned QDEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rtdtp_stream_if.sink    s_in,
    output logic            o_job_valid,
    output t_job            o_job,
    input  logic            i_job_pop
);
    localparam int unsigned BC_W = $clog2(BURST + 1);
    localparam int unsigned QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QC_W = $clog2(QDEPTH + 1);
    localparam int unsigned SUM_W = SAMPLE_W + $clog2(BURST + 1);
    localparam int unsigned AVG_SH = SUM_W + $clog2(BURST);
    localparam int unsigned PROD_W = 2 * SUM_W + 2;
    localparam logic [PROD_W-1:0] AVG_RECIP =
        PROD_W'(((64'd1 << AVG_SH) + 64'(BURST) - 64'd1) / 64'(BURST));

    t_job             r_q [QDEPTH];
    logic [QP_W-1:0]  r_wp, r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic [SUM_W-1:0] r_sum;
    logic [BC_W-1:0]  r_bc;
    logic [SUM_W-1:0] n_sum;
    logic [PROD_W-1:0] n_prod;
    logic             n_push;
    logic             acc;
    t_job             n_job;

    assign s_in.ready = (r_cnt != QC_W'(QDEPTH));
    assign acc = s_in.valid && s_in.ready;
    assign n_sum = r_sum + SUM_W'(s_in.data.adc_sample);
    // burst mean by reciprocal multiply, exact over the whole sum range
    assign n_prod = PROD_W'(n_sum) * AVG_RECIP;

    always_comb begin
        n_job.is_write = !s_in.data.mode;
        n_job.index    = s_in.data.table_index;
        n_job.res      = s_in.data.table_resistance;
        n_job.temp     = s_in.data.table_temperature;
        n_job.avg      = SAMPLE_W'(n_prod >> AVG_SH);
        n_push = acc && (!s_in.data.mode || (r_bc == BC_W'(BURST - 1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sum <= '0;
            r_bc  <= '0;
        end else begin
            if (acc && s_in.data.mode) begin
                if (r_bc == BC_W'(BURST - 1)) begin
                    r_bc  <= '0;
                    r_sum <= '0;
                end else begin
                    r_bc  <= r_bc + 1'b1;
                    r_sum <= n_sum;
                end
            end
            if (n_push) begin
                r_q[r_wp] <= n_job;
                r_wp <= (r_wp == QP_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_job_pop) begin
                r_rp <= (r_rp == QP_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(n_push) - QC_W'(i_job_pop);
        end
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job = r_q[r_rp];
endmodule

// File: hdl/rtdtp_back.sv
module rtdtp_back
    import rtdtp_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned WINDOW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SERIES_W-1:0]   i_series,
    input  logic [SAMPLE_W-1:0]   i_full_scale,
    input  logic [COUNT_W-1:0]    i_table_count,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_pop,
    rtdtp_stream_if.source        m_out
);
    localparam int unsigned TI_W = $clog2(TABLE_DEPTH);
    localparam int unsigned TN_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned WI_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned WC_W = $clog2(WINDOW + 1);
    localparam int unsigned WS_W = TEMP_W + $clog2(WINDOW + 1);
    localparam int unsigned DIV_W = 40;
    localparam int unsigned CN_W = (COUNT_W > TN_W) ? COUNT_W : TN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDIV, S_RWAIT, S_SRCH_RD, S_SRCH, S_PAIR, S_IMUL, S_IDIV,
        S_IWAIT, S_WIN, S_MDIV, S_MWAIT, S_OUT
    } t_state;

    t_state                   r_state;
    logic [RES_W-1:0]         r_tres [TABLE_DEPTH];
    logic signed [TEMP_W-1:0] r_ttemp [TABLE_DEPTH];
    logic signed [TEMP_W-1:0] r_win [WINDOW];
    logic [RES_W-1:0]         r_rd_res;
    logic signed [TEMP_W-1:0] r_rd_temp;
    logic [TI_W-1:0]          r_addr;
    logic [TN_W-1:0]          r_u;
    logic [TN_W-1:0]          r_n;
    logic [RES_W-1:0]         r_r;
    logic [RES_W-1:0]         r_rl;
    logic signed [TEMP_W-1:0] r_tl;
    logic signed [TEMP_W-1:0] r_t;
    logic signed [TEMP_W+RES_W+1:0] r_prod;
    logic                     r_neg;
    logic signed [WS_W-1:0]   r_wsum;
    logic [WC_W-1:0]          r_wcnt;
    logic [WI_W-1:0]          r_whead;
    logic signed [TEMP_W-1:0] r_avg;
    logic                     r_ovalid;
    t_out_item                r_odata;
    logic                     w_dstart;
    logic [DIV_W-1:0]         r_dnum, r_dden;
    logic                     w_ddone;
    logic [DIV_W-1:0]         w_dquot;
    logic [CN_W-1:0]          w_ncl;
    logic [TN_W-1:0]          w_n;
    logic signed [WS_W-1:0]   w_wsum;
    logic [WS_W-1:0]          w_wabs;

    rtdtp_divider #(.NUM_W(DIV_W), .DEN_W(DIV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    assign w_dstart = (r_state == S_RDIV) || (r_state == S_IDIV) || (r_state == S_MDIV);

    always_comb begin
        w_ncl = CN_W'(i_table_count);
        if (w_ncl == '0) w_ncl = CN_W'(1);
        if (w_ncl > CN_W'(TABLE_DEPTH)) w_ncl = CN_W'(TABLE_DEPTH);
        w_n = TN_W'(w_ncl);
        w_wsum = r_wsum + WS_W'(r_t);
        if (r_wcnt == WC_W'(WINDOW)) w_wsum = w_wsum - WS_W'(r_win[r_whead]);
        w_wabs = w_wsum[WS_W-1] ? WS_W'(-w_wsum) : WS_W'(w_wsum);
    end

    always_ff @(posedge i_clk) begin
        r_rd_res  <= r_tres[r_addr];
        r_rd_temp <= r_ttemp[r_addr];
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wsum   <= '0;
            r_wcnt   <= '0;
            r_whead  <= '0;
        end else begin
            if (m_out.valid && m_out.ready && (r_state != S_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.is_write) begin
                            if (32'(i_job.index) < TABLE_DEPTH) begin
                                r_tres[TI_W'(i_job.index)]  <= i_job.res;
                                r_ttemp[TI_W'(i_job.index)] <= i_job.temp;
                            end
                        end else if (i_job.avg >= i_full_scale) begin
                            r_r <= RES_SAT;
                            r_addr <= '0;
                            r_u <= '0;
                            r_n <= w_n;
                            r_state <= S_SRCH_RD;
                        end else begin
                            r_dnum <= DIV_W'({i_series, 4'b0}) * DIV_W'(i_job.avg);
                            r_dden <= DIV_W'(i_full_scale - i_job.avg);
                            r_n <= w_n;
                            r_state <= S_RDIV;
                        end
                    end
                end
                S_RDIV: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (w_ddone) begin
                        r_r <= (w_dquot > DIV_W'(RES_SAT)) ? RES_SAT : RES_W'(w_dquot);
                        r_addr <= '0;
                        r_u <= '0;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: r_state <= S_SRCH;
                S_SRCH: begin
                    // each entry is read in S_SRCH_RD, then compared here; memory read registered
                    if (r_r < r_rd_res) begin
                        if (r_u == '0) begin
                            r_t <= r_rd_temp;
                            r_state <= S_WIN;
                        end else begin
                            r_addr <= TI_W'(r_u - 1'b1);
                            r_state <= S_PAIR;
                        end
                    end else if (r_u + 1'b1 == r_n) begin
                        r_t <= r_rd_temp;
                        r_state <= S_WIN;
                    end else begin
                        r_u <= r_u + 1'b1;
                        r_addr <= TI_W'(r_u + 1'b1);
                        r_rl <= r_rd_res;
                        r_tl <= r_rd_temp;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_PAIR: begin
                    // r_rl/r_tl hold lower point, r_rd_* still upper point
                    r_prod <= (TEMP_W+RES_W+2)'(
                        ($signed({r_rd_temp[TEMP_W-1], r_rd_temp}) -
                         $signed({r_tl[TEMP_W-1], r_tl})) *
                        $signed({1'b0, r_r - r_rl}));
                    r_dden <= DIV_W'(r_rd_res - r_rl);
                    r_state <= S_IMUL;
                end
                S_IMUL: begin
                    r_neg <= r_prod[TEMP_W+RES_W+1];
                    r_dnum <= r_prod[TEMP_W+RES_W+1] ? DIV_W'(-r_prod) : DIV_W'(r_prod);
                    r_state <= S_IDIV;
                end
                S_IDIV: begin
                    r_state <= S_IWAIT;
                end
                S_IWAIT: begin
                    if (w_ddone) begin
                        r_t <= r_tl + (r_neg ? -TEMP_W'(w_dquot) : TEMP_W'(w_dquot));
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_win[r_whead] <= r_t;
                    r_wsum <= w_wsum;
                    if (r_wcnt != WC_W'(WINDOW)) r_wcnt <= r_wcnt + 1'b1;
                    r_whead <= (r_whead == WI_W'(WINDOW - 1)) ? '0 : r_whead + 1'b1;
                    r_neg <= w_wsum[WS_W-1];
                    r_dnum <= DIV_W'(w_wabs);
                    r_dden <= (r_wcnt != WC_W'(WINDOW)) ? DIV_W'(r_wcnt + 1'b1)
                                                        : DIV_W'(r_wcnt);
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_ddone) begin
                        r_avg <= r_neg ? -TEMP_W'(w_dquot) : TEMP_W'(w_dquot);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata.resistance <= r_r;
                        r_odata.temperature <= r_t;
                        r_odata.smoothed_temperature <= r_avg;
                        r_odata.window_fill <= FILL_W'(r_wcnt);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/rtd_temperature_pipeline_unit.sv
// channel | dir | payload                                     | handshake
// s_in    | in  | mode, table fields, adc_sample              | valid/ready
// m_out   | out | resistance, temperature, smoothed, fill     | valid/ready
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data             | write only
// a burst-ending sample keeps the back busy for up to three divisions in one
// shared serial divider plus a read state and a compare state per table entry
// table writes are queued and other samples only summed by the front; a two-entry queue
// decouples front and back and stalls the input only when full
// synchronous active-low reset; result register holds until taken
module rtd_temperature_pipeline_unit
    import rtdtp_pkg::*;
#(
    parameter int unsigned BURST = 10,
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned WINDOW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rtdtp_stream_if.sink          s_in,
    rtdtp_stream_if.source        m_out
);
    logic [SERIES_W-1:0] r_series;
    logic [SAMPLE_W-1:0] r_full;
    logic [COUNT_W-1:0]  r_tcnt;
    logic                w_jv, w_pop;
    t_job                w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series <= SERIES_W'(1000);
            r_full   <= SAMPLE_W'(4095);
            r_tcnt   <= COUNT_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SERIES:     r_series <= i_cfg_data;
                CFG_FULL_SCALE: r_full <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TABLE_CNT:  r_tcnt <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    rtdtp_front #(.BURST(BURST), .QDEPTH(2)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (s_in),
        .o_job_valid (w_jv),
        .o_job       (w_job),
        .i_job_pop   (w_pop)
    );

    rtdtp_back #(.TABLE_DEPTH(TABLE_DEPTH), .WINDOW(WINDOW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_series      (r_series),
        .i_full_scale  (r_full),
        .i_table_count (r_tcnt),
        .i_job_valid   (w_jv),
        .i_job         (w_job),
        .o_job_pop     (w_pop),
        .m_out         (m_out)
    );
endmodule
